FILE: design/gas_pkg.sv
// ----------------------------------------------------------------------------
// gas_pkg
// Shared types, codes and the logistic lookup table of the Gibbs sampler.
// ----------------------------------------------------------------------------
package gas_pkg;

    localparam int NODES       = 64;
    localparam int MAX_NODES   = 64;
    localparam int NODE_LIMIT  = (MAX_NODES < NODES) ? MAX_NODES : NODES;
    localparam int LOGIT_DEPTH = 256;
    localparam int TIX_W       = $clog2(LOGIT_DEPTH);
    localparam int DIV_STEPS   = 15;

    typedef enum logic [1:0] {
        MODE_COL    = 2'd0,
        MODE_WEIGHT = 2'd1,
        MODE_SPIN   = 2'd2,
        MODE_UPDATE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_BIAS     = 2'd0,
        CFG_COUPLING = 2'd1,
        CFG_NODES    = 2'd2,
        CFG_SPARE    = 2'd3
    } cfg_index_t;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_RD   = 13'b0000000000010,
        S_POP  = 13'b0000000000100,
        S_DIV  = 13'b0000000001000,
        S_MUL  = 13'b0000000010000,
        S_XSAT = 13'b0000000100000,
        S_TAB  = 13'b0000001000000,
        S_SPIN = 13'b0000010000000,
        S_SRD  = 13'b0000100000000,
        S_SPOP = 13'b0001000000000,
        S_SDIV = 13'b0010000000000,
        S_SACC = 13'b0100000000000,
        S_EMIT = 13'b1000000000000
    } state_t;

    typedef struct packed {
        logic load_take;
        logic upd_take;
        logic scan_sel;
        logic pop_load;
        logic div_step;
        logic mul;
        logic xsat;
        logic tab;
        logic spin;
        logic stat_clear;
        logic stat_acc;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic is_last;
        logic scan_last;
        logic out_free;
    } status_t;

    typedef logic [15:0] logit_tab_t [LOGIT_DEPTH];

    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], a[i]};
            if (r >= {1'b0, b}) begin
                r    = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint exp_neg_q30(input longint u);
        longint v;
        longint term;
        longint sum;
        v    = u >>> 4;
        term = 64'sd1 <<< 30;
        sum  = 64'sd1 <<< 30;
        for (int n = 1; n <= 12; n++) begin
            term = longint'(udiv64(64'((term * v) >>> 30), 64'(n)));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        for (int s = 0; s < 4; s++) begin
            sum = (sum * sum) >>> 30;
        end
        return sum;
    endfunction

    function automatic logit_tab_t logit_build();
        logit_tab_t t;
        longint off;
        longint mag;
        longint e;
        longint den;
        longint num;
        longint p;
        for (int k = 0; k < LOGIT_DEPTH; k++) begin
            off = 16 * longint'(k) - 8 * longint'(LOGIT_DEPTH);
            mag = (off < 0) ? -off : off;
            e   = exp_neg_q30((mag <<< 30) / LOGIT_DEPTH);
            den = (64'sd1 <<< 30) + e;
            num = (off >= 0) ? (64'sd1 <<< 46) : (e <<< 16);
            p   = longint'(udiv64(64'(num + (den >>> 1)), 64'(den)));
            if (p > 65535) p = 65535;
            t[k] = p[15:0];
        end
        return t;
    endfunction

    localparam logit_tab_t LOGIT_TABLE = logit_build();

endpackage

FILE: design/gas_in_if.sv
// ----------------------------------------------------------------------------
// gas_in_if
// Request channel carrying load and update items into the sampler.
// ----------------------------------------------------------------------------
interface gas_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [5:0]  node_index;
    logic [63:0] load_word;
    logic [15:0] random_draw;

    modport source (output valid, output mode, output node_index, output load_word,
                    output random_draw, input ready);
    modport sink (input valid, input mode, input node_index, input load_word,
                  input random_draw, output ready);
endinterface

FILE: design/gas_out_if.sv
// ----------------------------------------------------------------------------
// gas_out_if
// Result channel carrying one sampled node per update request.
// ----------------------------------------------------------------------------
interface gas_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  updated_node;
    logic        new_spin;
    logic        sweep_end;
    logic [6:0]  ones_count;
    logic [20:0] neighbor_stat;

    modport source (output valid, output updated_node, output new_spin, output sweep_end,
                    output ones_count, output neighbor_stat, input ready);
    modport sink (input valid, input updated_node, input new_spin, input sweep_end,
                  input ones_count, input neighbor_stat, output ready);
endinterface

FILE: design/gas_cfg_if.sv
// ----------------------------------------------------------------------------
// gas_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface gas_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/gibbs_autologistic_sampler_core.sv
// ----------------------------------------------------------------------------
// gibbs_autologistic_sampler_core
// Gibbs sampler over a binary autologistic random field of up to 64 nodes.
// ----------------------------------------------------------------------------
// Requests either load an adjacency column, a node weight or the spin vector
// (no result) or resample the next node of the sweep (one result). An update
// runs through a memory read, a popcount, a bit-serial divide by the node
// weight, a multiply, saturation, the logistic table lookup and the spin
// write. On the last node of a sweep the block walks every node in use
// through the same read, popcount and divide path, accumulating the
// quotients into the neighbour statistic.
// Loads are accepted while a result waits in the output register.
module gibbs_autologistic_sampler_core (
    input logic       clk,
    input logic       rst_n,
    gas_in_if.sink    sample_in,
    gas_out_if.source result_out,
    gas_cfg_if.sink   cfg
);

    gas_pkg::cmd_t    cmd;
    gas_pkg::status_t status;
    logic             cfg_take;

    assign cfg.ready = 1'b1;
    assign cfg_take  = cfg.valid && cfg.ready;

    gas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_mode  (sample_in.mode),
        .in_ready (sample_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    gas_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .in_mode           (sample_in.mode),
        .in_node_index     (sample_in.node_index),
        .in_load_word      (sample_in.load_word),
        .in_random_draw    (sample_in.random_draw),
        .cfg_take          (cfg_take),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .out_ready         (result_out.ready),
        .out_valid         (result_out.valid),
        .out_updated_node  (result_out.updated_node),
        .out_new_spin      (result_out.new_spin),
        .out_sweep_end     (result_out.sweep_end),
        .out_ones_count    (result_out.ones_count),
        .out_neighbor_stat (result_out.neighbor_stat)
    );

    // statistics only on the last node of a sweep
    a_stat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && !result_out.sweep_end
            |-> result_out.ones_count == 7'd0 && result_out.neighbor_stat == 21'd0)
        else $error("statistics nonzero off sweep end");

    // an update request holds off the next request
    a_upd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_in.valid && sample_in.ready && sample_in.mode == gas_pkg::MODE_UPDATE
            |=> !sample_in.ready)
        else $error("request taken during update");

    // a load request leaves the block ready again in the next cycle
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        sample_in.valid && sample_in.ready && sample_in.mode != gas_pkg::MODE_UPDATE
            |=> sample_in.ready)
        else $error("load did not complete");

endmodule

FILE: design/gas_ctrl.sv
// ----------------------------------------------------------------------------
// gas_ctrl
// Sequencer for update requests and the end-of-sweep statistic walk.
// ----------------------------------------------------------------------------
module gas_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_mode,
    output logic              in_ready,
    input  gas_pkg::status_t  status,
    output gas_pkg::cmd_t     cmd
);

    gas_pkg::state_t state_reg;
    gas_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gas_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == gas_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            gas_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode == gas_pkg::MODE_UPDATE)
                    begin
                        cmd.upd_take = 1'b1;
                        state_next   = gas_pkg::S_RD;
                    end
                    else
                    begin
                        cmd.load_take = 1'b1;
                    end
                end
            end
            gas_pkg::S_RD:
            begin
                state_next = gas_pkg::S_POP;
            end
            gas_pkg::S_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = gas_pkg::S_DIV;
            end
            gas_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = gas_pkg::S_MUL;
                end
            end
            gas_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = gas_pkg::S_XSAT;
            end
            gas_pkg::S_XSAT:
            begin
                cmd.xsat   = 1'b1;
                state_next = gas_pkg::S_TAB;
            end
            gas_pkg::S_TAB:
            begin
                cmd.tab    = 1'b1;
                state_next = gas_pkg::S_SPIN;
            end
            gas_pkg::S_SPIN:
            begin
                cmd.spin = 1'b1;
                if (status.is_last)
                begin
                    cmd.stat_clear = 1'b1;
                    state_next     = gas_pkg::S_SRD;
                end
                else
                begin
                    state_next = gas_pkg::S_EMIT;
                end
            end
            gas_pkg::S_SRD:
            begin
                cmd.scan_sel = 1'b1;
                state_next   = gas_pkg::S_SPOP;
            end
            gas_pkg::S_SPOP:
            begin
                cmd.scan_sel = 1'b1;
                cmd.pop_load = 1'b1;
                state_next   = gas_pkg::S_SDIV;
            end
            gas_pkg::S_SDIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = gas_pkg::S_SACC;
                end
            end
            gas_pkg::S_SACC:
            begin
                cmd.stat_acc = 1'b1;
                state_next   = status.scan_last ? gas_pkg::S_EMIT : gas_pkg::S_SRD;
            end
            gas_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = gas_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gas_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/gas_dp.sv
// ----------------------------------------------------------------------------
// gas_dp
// Datapath: spin state, column and weight memories, divider, multiplier,
// logistic lookup, statistic accumulator and result register.
// ----------------------------------------------------------------------------
module gas_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  gas_pkg::cmd_t     cmd,
    output gas_pkg::status_t  status,
    input  logic [1:0]        in_mode,
    input  logic [5:0]        in_node_index,
    input  logic [63:0]       in_load_word,
    input  logic [15:0]       in_random_draw,
    input  logic              cfg_take,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [5:0]        out_updated_node,
    output logic              out_new_spin,
    output logic              out_sweep_end,
    output logic [6:0]        out_ones_count,
    output logic [20:0]       out_neighbor_stat
);

    localparam logic [6:0] LIMIT = 7'(gas_pkg::NODE_LIMIT);

    logic signed [15:0] bias_reg;
    logic signed [15:0] coupling_reg;
    logic [6:0]         node_count_reg;
    logic [63:0]        spins_reg;
    logic [5:0]         next_node_reg;

    logic [63:0] col_mem [gas_pkg::NODES];
    logic [15:0] wt_mem [gas_pkg::NODES];
    logic [63:0] col_q;
    logic [15:0] w_q;

    logic [5:0]  node_reg;
    logic [6:0]  scan_reg;
    logic [15:0] draw_reg;
    logic [15:0] wd_reg;
    logic [14:0] dvd_reg;
    logic [15:0] rem_reg;
    logic [14:0] quo_reg;
    logic [3:0]  cnt_reg;
    logic signed [31:0] prod_reg;
    logic signed [15:0] x_reg;
    logic [15:0] prob_reg;
    logic        spin_reg;
    logic        last_reg;
    logic [20:0] acc_reg;
    logic        out_valid_reg;

    logic [6:0]  n_use;
    logic [63:0] mask;
    logic [5:0]  rd_addr;
    logic [6:0]  pop;
    logic [16:0] rem_sh;
    logic        ge;
    logic signed [32:0] prod_full;
    logic signed [23:0] sh;
    logic signed [24:0] xsum;
    logic signed [15:0] xsat;
    logic [11:0] xoff;
    logic [gas_pkg::TIX_W-1:0] tix;
    logic        new_spin;

    always_comb
    begin
        if (node_count_reg < 7'd2) n_use = 7'd2;
        else if (node_count_reg > LIMIT) n_use = LIMIT;
        else n_use = node_count_reg;
    end

    assign mask    = (n_use >= 7'd64) ? '1 : ((64'd1 << n_use) - 64'd1);
    assign rd_addr = cmd.scan_sel ? scan_reg[5:0] : node_reg;
    assign pop     = 7'($countones(spins_reg & col_q & mask));

    assign rem_sh = {rem_reg, dvd_reg[14]};
    assign ge     = (rem_sh >= {1'b0, wd_reg});

    assign prod_full = coupling_reg * $signed({2'b00, quo_reg});
    assign sh        = prod_reg[31:8];
    assign xsum      = 25'(bias_reg) + 25'(sh);

    always_comb
    begin
        if (xsum > 25'sd32767) xsat = 16'sh7fff;
        else if (xsum < -25'sd32768) xsat = 16'sh8000;
        else xsat = xsum[15:0];
    end

    assign xoff = 12'(x_reg + 16'sd2048);

    always_comb
    begin
        if (x_reg < -16'sd2048) tix = '0;
        else if (x_reg >= 16'sd2048) tix = '1;
        else tix = xoff[11 -: gas_pkg::TIX_W];
    end

    assign new_spin = (draw_reg < prob_reg);

    assign status.div_last  = (cnt_reg == 4'(gas_pkg::DIV_STEPS - 1));
    assign status.is_last   = ({1'b0, node_reg} == n_use - 7'd1);
    assign status.scan_last = (scan_reg == n_use - 7'd1);
    assign status.out_free  = !out_valid_reg || out_ready;

    // configuration and sweep control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg       <= '0;
            coupling_reg   <= '0;
            node_count_reg <= 7'd64;
            spins_reg      <= '0;
            next_node_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_take)
            begin
                unique case (cfg_index)
                    gas_pkg::CFG_BIAS:     bias_reg       <= cfg_data;
                    gas_pkg::CFG_COUPLING: coupling_reg   <= cfg_data;
                    gas_pkg::CFG_NODES:    node_count_reg <= cfg_data[6:0];
                    default:               ;
                endcase
            end
            if (cmd.load_take && in_mode == gas_pkg::MODE_SPIN)
            begin
                spins_reg     <= in_load_word;
                next_node_reg <= '0;
            end
            if (cmd.spin)
            begin
                spins_reg[node_reg] <= new_spin;
                next_node_reg       <= status.is_last ? 6'd0 : node_reg + 6'd1;
            end
            if (cmd.emit) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load_take && in_mode == gas_pkg::MODE_COL)
        begin
            col_mem[in_node_index] <= in_load_word;
        end
        if (cmd.load_take && in_mode == gas_pkg::MODE_WEIGHT)
        begin
            wt_mem[in_node_index] <= in_load_word[15:0];
        end
        col_q <= col_mem[rd_addr];
        w_q   <= wt_mem[rd_addr];
    end

    // arithmetic pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.upd_take)
        begin
            node_reg <= ({1'b0, next_node_reg} < n_use) ? next_node_reg : 6'd0;
            draw_reg <= in_random_draw;
        end
        if (cmd.pop_load)
        begin
            dvd_reg <= {pop, 8'd0};
            rem_reg <= '0;
            cnt_reg <= '0;
            wd_reg  <= (w_q == 16'd0) ? 16'd1 : w_q;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? 16'(rem_sh - {1'b0, wd_reg}) : rem_sh[15:0];
            quo_reg <= {quo_reg[13:0], ge};
            dvd_reg <= {dvd_reg[13:0], 1'b0};
            cnt_reg <= cnt_reg + 4'd1;
        end
        if (cmd.mul)  prod_reg <= prod_full[31:0];
        if (cmd.xsat) x_reg    <= xsat;
        if (cmd.tab)  prob_reg <= gas_pkg::LOGIT_TABLE[tix];
        if (cmd.spin)
        begin
            spin_reg <= new_spin;
            last_reg <= status.is_last;
        end
        if (cmd.stat_clear)
        begin
            acc_reg  <= '0;
            scan_reg <= '0;
        end
        if (cmd.stat_acc)
        begin
            acc_reg  <= acc_reg + 21'(quo_reg);
            scan_reg <= scan_reg + 7'd1;
        end
        if (cmd.emit)
        begin
            out_updated_node  <= node_reg;
            out_new_spin      <= spin_reg;
            out_sweep_end     <= last_reg;
            out_ones_count    <= last_reg ? 7'($countones(spins_reg & mask)) : 7'd0;
            out_neighbor_stat <= last_reg ? acc_reg : 21'd0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
